[rtl/spc_pkg.sv]
// package for the spherical-to-cartesian scaler: constants, types and arithmetic helpers
`timescale 1ns / 1ps
package spc_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int TABLE_LEN    = 30;
    localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int OFF_SHIFT    = FRAC_BITS - 12;
    localparam int PHASE_LSB    = FRAC_BITS - 4;
    localparam int CW           = 34;
    localparam int NUM_MULT     = 5;

    localparam logic [31:0] INV_TWO_PI_HI = 32'h028BE60D;
    localparam logic [31:0] INV_TWO_PI_LO = 32'hB9391055;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] REG_CONTROL    = 3'd0;
    localparam logic [2:0] REG_OFFSET     = 3'd1;
    localparam logic [2:0] REG_MULT_FIRST = 3'd2;
    localparam logic [2:0] REG_MULT_LAST  = 3'd6;

    localparam logic [6:0]  CONTROL_RESET = 7'd1;
    localparam logic [59:0] OFFSET_RESET  = 60'd0;
    localparam logic [51:0] MULT_RESET    = 52'h3E801000000;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_RADIUS_X,
        MODE_RADIUS_Z,
        MODE_RADIUS_Y
    } mode_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic [30:0]        distance;
        logic [9:0]         iter;
    } item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] q;
    } cordic_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic signed [CW-1:0] a;
        case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        cordic_t r;
        cx = c.x;
        cy = c.y;
        dx = cy >>> i;
        dy = cx >>> i;
        if (!c.q[CW-1]) begin
            r.x = cx - dx;
            r.y = cy + dy;
            r.q = c.q - atan_turn(i);
        end else begin
            r.x = cx + dx;
            r.y = cy - dy;
            r.q = c.q + atan_turn(i);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/spherical_to_cartesian_scaler.sv]
// throughput: one request per cycle while no finished result waits on m_ready;
// one cordic step per pipeline stage, two angle lanes
// the whole pipeline holds while a finished result waits on m_ready
// reset (synchronous, aresetn low) clears all stage valid bits and the configuration
// registers to control 1, offsets 0, multipliers 0x3E801000000
`timescale 1ns / 1ps
module spherical_to_cartesian_scaler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    input  logic signed [31:0] s_in_z,
    input  logic signed [31:0] s_in_w,
    input  logic [30:0]        s_in_distance,
    input  logic [9:0]         s_iteration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [31:0] m_out_w,
    output logic [30:0]        m_out_distance
);

    localparam int NS    = spc_pkg::NSTEPS;
    localparam int S_M1  = NS + 3;
    localparam int DEPTH = NS + 11;
    localparam int FB    = spc_pkg::FRAC_BITS;
    localparam int CW    = spc_pkg::CW;
    localparam int NM    = spc_pkg::NUM_MULT;

    // configuration
    logic [6:0]  ctrl_reg;
    logic [59:0] off_reg;
    logic [51:0] mult_reg [NM];
    spc_pkg::mode_t mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= spc_pkg::CONTROL_RESET;
            off_reg  <= spc_pkg::OFFSET_RESET;
            for (int k = 0; k < NM; k++) begin
                mult_reg[k] <= spc_pkg::MULT_RESET;
            end
        end else if (cfg_we) begin
            if (cfg_index == spc_pkg::REG_CONTROL) begin
                ctrl_reg <= cfg_data[6:0];
            end else if (cfg_index == spc_pkg::REG_OFFSET) begin
                off_reg <= cfg_data;
            end else if (cfg_index >= spc_pkg::REG_MULT_FIRST &&
                         cfg_index <= spc_pkg::REG_MULT_LAST) begin
                mult_reg[3'(cfg_index - spc_pkg::REG_MULT_FIRST)] <= cfg_data[51:0];
            end
        end
    end

    assign mode = spc_pkg::mode_t'(ctrl_reg[1:0]);

    // pipeline control
    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // stage a: operand selection and angle magnitudes
    spc_pkg::item_t     itm_reg [S_M1+1];
    logic signed [31:0] rad_reg [S_M1];
    logic [31:0]        a_mag_reg [2];
    logic               a_neg_reg [2];
    logic signed [31:0] rad_next;
    logic signed [31:0] ang [2];
    spc_pkg::item_t     itm_next;

    always_comb begin
        case (mode)
            spc_pkg::MODE_RADIUS_Z: begin
                rad_next = s_in_z;
                ang[0]   = s_in_x;
                ang[1]   = s_in_y;
            end
            spc_pkg::MODE_RADIUS_Y: begin
                rad_next = s_in_y;
                ang[0]   = s_in_x;
                ang[1]   = s_in_z;
            end
            default: begin
                rad_next = s_in_x;
                ang[0]   = s_in_y;
                ang[1]   = s_in_z;
            end
        endcase
        itm_next.x        = s_in_x;
        itm_next.y        = s_in_y;
        itm_next.z        = s_in_z;
        itm_next.w        = s_in_w;
        itm_next.distance = s_in_distance;
        itm_next.iter     = s_iteration;
    end

    // stage b: angle times 1/(2 pi) in two partial products
    logic [63:0] b_lo_reg [2];
    logic [63:0] b_hi_reg [2];
    logic        b_neg_reg [2];

    // stage c and cordic stages
    spc_pkg::cordic_t cor_reg  [NS+1][2];
    logic             flip_reg [NS+1][2];
    spc_pkg::cordic_t cor_next [2];
    logic             flip_next [2];

    always_comb begin
        logic [63:0] hi;
        logic [31:0] p;
        logic [31:0] pf;
        for (int j = 0; j < 2; j++) begin
            hi = b_hi_reg[j] + (b_lo_reg[j] >> 32);
            p  = hi[spc_pkg::PHASE_LSB +: 32];
            if (b_neg_reg[j]) begin
                p = 32'd0 - p;
            end
            pf = p + 32'h40000000;
            flip_next[j] = pf[31];
            if (pf[31]) begin
                p = p - 32'h80000000;
            end
            cor_next[j].x = spc_pkg::CORDIC_GAIN;
            cor_next[j].y = '0;
            cor_next[j].q = {{(CW-32){p[31]}}, p};
        end
    end

    // stage m1: radius times sine and cosine of the first angle
    logic signed [35:0]   sn_reg;
    logic signed [35:0]   rc_reg;
    logic signed [CW-1:0] s2_reg;
    logic signed [CW-1:0] c2_reg;
    logic signed [35:0]   sn_next;
    logic signed [35:0]   rc_next;
    logic signed [CW-1:0] sc [2];
    logic signed [CW-1:0] cc [2];

    always_comb begin
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cx;
        logic signed [65:0]   ps;
        logic signed [65:0]   pc;
        for (int j = 0; j < 2; j++) begin
            cy = cor_reg[NS][j].y;
            cx = cor_reg[NS][j].x;
            sc[j] = flip_reg[NS][j] ? -cy : cy;
            cc[j] = flip_reg[NS][j] ? -cx : cx;
        end
        ps = 66'(rad_reg[S_M1-1]) * 66'(sc[0]);
        pc = 66'(rad_reg[S_M1-1]) * 66'(cc[0]);
        sn_next = ps[65:30];
        rc_next = pc[65:30];
    end

    // stage m2 onward: x, y, z of the item hold the converted point
    spc_pkg::item_t tl_reg [7];
    spc_pkg::item_t cv_next;
    spc_pkg::item_t off_next;
    spc_pkg::item_t mul_next [NM];

    always_comb begin
        logic signed [69:0] pa;
        logic signed [69:0] pb;
        logic signed [31:0] tsc;
        logic signed [31:0] tss;
        logic signed [31:0] trc;
        spc_pkg::item_t     it;
        pa  = 70'(sn_reg) * 70'(c2_reg);
        pb  = 70'(sn_reg) * 70'(s2_reg);
        tsc = spc_pkg::sat32(72'($signed(pa[69:30])));
        tss = spc_pkg::sat32(72'($signed(pb[69:30])));
        trc = spc_pkg::sat32(72'(rc_reg));
        it  = itm_reg[S_M1];
        cv_next = it;
        case (mode)
            spc_pkg::MODE_RADIUS_X: begin
                cv_next.x = tsc;
                cv_next.y = tss;
                cv_next.z = trc;
            end
            spc_pkg::MODE_RADIUS_Z: begin
                cv_next.x = tss;
                cv_next.y = trc;
                cv_next.z = tsc;
            end
            spc_pkg::MODE_RADIUS_Y: begin
                cv_next.x = tss;
                cv_next.y = tsc;
                cv_next.z = trc;
            end
            default: begin
                cv_next = it;
            end
        endcase
    end

    // offset stage
    always_comb begin
        logic signed [19:0] ox;
        logic signed [19:0] oy;
        logic signed [19:0] oz;
        ox = off_reg[19:0];
        oy = off_reg[39:20];
        oz = off_reg[59:40];
        off_next   = tl_reg[0];
        off_next.x = spc_pkg::sat32(72'(tl_reg[0].x) + (72'(ox) <<< spc_pkg::OFF_SHIFT));
        off_next.y = spc_pkg::sat32(72'(tl_reg[0].y) + (72'(oy) <<< spc_pkg::OFF_SHIFT));
        off_next.z = spc_pkg::sat32(72'(tl_reg[0].z) + (72'(oz) <<< spc_pkg::OFF_SHIFT));
    end

    // gated multiplier stages
    always_comb begin
        logic signed [31:0] scl;
        logic [31:0]        asc;
        logic [9:0]         first;
        logic [9:0]         stop;
        logic               apply;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] pz;
        logic signed [63:0] pw;
        logic [62:0]        pd;
        logic [62:0]        ds;
        spc_pkg::item_t     it;
        for (int k = 0; k < NM; k++) begin
            it    = tl_reg[k+1];
            scl   = mult_reg[k][31:0];
            asc   = scl[31] ? 32'd0 - mult_reg[k][31:0] : mult_reg[k][31:0];
            first = mult_reg[k][41:32];
            stop  = mult_reg[k][51:42];
            apply = ctrl_reg[2+k] && it.iter >= first && it.iter < stop;
            px = 64'(it.x) * 64'(scl);
            py = 64'(it.y) * 64'(scl);
            pz = 64'(it.z) * 64'(scl);
            pw = 64'(it.w) * 64'(scl);
            pd = 63'(it.distance) * 63'(asc);
            ds = pd >> FB;
            mul_next[k] = it;
            if (apply) begin
                mul_next[k].x = spc_pkg::sat32(72'(px >>> FB));
                mul_next[k].y = spc_pkg::sat32(72'(py >>> FB));
                mul_next[k].z = spc_pkg::sat32(72'(pz >>> FB));
                mul_next[k].w = spc_pkg::sat32(72'(pw >>> FB));
                mul_next[k].distance = (ds > 63'd2147483647) ? 31'h7FFFFFFF : ds[30:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            itm_reg[0] <= itm_next;
            rad_reg[0] <= rad_next;
            for (int j = 0; j < 2; j++) begin
                a_mag_reg[j] <= ang[j][31] ? 32'd0 - ang[j] : ang[j];
                a_neg_reg[j] <= ang[j][31];
                b_lo_reg[j]  <= 64'(a_mag_reg[j]) * 64'(spc_pkg::INV_TWO_PI_LO);
                b_hi_reg[j]  <= 64'(a_mag_reg[j]) * 64'(spc_pkg::INV_TWO_PI_HI);
                b_neg_reg[j] <= a_neg_reg[j];
                cor_reg[0][j]  <= cor_next[j];
                flip_reg[0][j] <= flip_next[j];
                for (int k = 0; k < NS; k++) begin
                    cor_reg[k+1][j]  <= spc_pkg::cordic_step(cor_reg[k][j], k);
                    flip_reg[k+1][j] <= flip_reg[k][j];
                end
            end
            for (int k = 1; k <= S_M1; k++) begin
                itm_reg[k] <= itm_reg[k-1];
            end
            for (int k = 1; k < S_M1; k++) begin
                rad_reg[k] <= rad_reg[k-1];
            end
            sn_reg <= sn_next;
            rc_reg <= rc_next;
            s2_reg <= sc[1];
            c2_reg <= cc[1];
            tl_reg[0] <= cv_next;
            tl_reg[1] <= off_next;
            for (int k = 0; k < NM; k++) begin
                tl_reg[k+2] <= mul_next[k];
            end
        end
    end

    assign m_out_x        = tl_reg[6].x;
    assign m_out_y        = tl_reg[6].y;
    assign m_out_z        = tl_reg[6].z;
    assign m_out_w        = tl_reg[6].w;
    assign m_out_distance = tl_reg[6].distance;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request did not enter the first stage");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !vld_reg[DEPTH-2] |=> !m_valid)
        else $error("result repeated after it was taken");

endmodule

[sim/spc_checker.sv]
// request/result monitor with scoreboard and a bit-exact predictor of the scaler
`timescale 1ns / 1ps
module spc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    input  logic signed [31:0] s_in_z,
    input  logic signed [31:0] s_in_w,
    input  logic [30:0]        s_in_distance,
    input  logic [9:0]         s_iteration,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_out_x,
    input  logic signed [31:0] m_out_y,
    input  logic signed [31:0] m_out_z,
    input  logic signed [31:0] m_out_w,
    input  logic [30:0]        m_out_distance,
    output int                 errors,
    output int                 pending,
    output int                 requests_taken
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic [30:0]        distance;
    } point_t;

    localparam logic [63:0] TURNS_PER_RAD_Q60 = 64'h028BE60DB9391055;
    localparam longint ARC_TURNS [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic [6:0]  ctrl_reg;
    logic [59:0] offset_reg;
    logic [51:0] mult_reg [spc_pkg::NUM_MULT];
    point_t      expected_points [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        logic [31:0]     ph;
        bit              neg;
        bit              flip;
        longint          q;
        longint          cx;
        longint          cy;
        longint          dx;
        longint          dy;
        neg = ang < 0;
        mag = neg ? -ang : ang;
        lo = mag * {32'd0, TURNS_PER_RAD_Q60[31:0]};
        hi = mag * {32'd0, TURNS_PER_RAD_Q60[63:32]} + (lo >> 32);
        ph = 32'(hi >> spc_pkg::PHASE_LSB);
        if (neg) begin
            ph = 32'd0 - ph;
        end
        flip = ((ph + 32'h40000000) & 32'h80000000) != 0;
        if (flip) begin
            ph = ph - 32'h80000000;
        end
        q = longint'($signed(ph));
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < spc_pkg::NSTEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (q >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                q = q - ARC_TURNS[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                q = q + ARC_TURNS[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        sn = cy;
        cs = cx;
    endfunction

    function automatic point_t transform_point(input longint x, input longint y,
                                               input longint z, input longint w,
                                               input longint d, input logic [9:0] iter);
        longint t [3];
        longint s1;
        longint c1;
        longint s2;
        longint c2;
        longint rs;
        longint sc;
        longint asc;
        longint off;
        logic [51:0] m;
        point_t r;
        t[0] = x;
        t[1] = y;
        t[2] = z;
        case (spc_pkg::mode_t'(ctrl_reg[1:0]))
            spc_pkg::MODE_RADIUS_X: begin
                sin_cos(y, s1, c1);
                sin_cos(z, s2, c2);
                rs = (x * s1) >>> 30;
                t[0] = clamp32((rs * c2) >>> 30);
                t[1] = clamp32((rs * s2) >>> 30);
                t[2] = clamp32((x * c1) >>> 30);
            end
            spc_pkg::MODE_RADIUS_Z: begin
                sin_cos(x, s1, c1);
                sin_cos(y, s2, c2);
                rs = (z * s1) >>> 30;
                t[0] = clamp32((rs * s2) >>> 30);
                t[1] = clamp32((z * c1) >>> 30);
                t[2] = clamp32((rs * c2) >>> 30);
            end
            spc_pkg::MODE_RADIUS_Y: begin
                sin_cos(x, s1, c1);
                sin_cos(z, s2, c2);
                rs = (y * s1) >>> 30;
                t[0] = clamp32((rs * s2) >>> 30);
                t[1] = clamp32((rs * c2) >>> 30);
                t[2] = clamp32((y * c1) >>> 30);
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            off = longint'($signed(offset_reg[20*k +: 20]));
            t[k] = clamp32(t[k] + (off <<< spc_pkg::OFF_SHIFT));
        end
        for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
            m = mult_reg[k];
            sc = longint'($signed(m[31:0]));
            asc = sc < 0 ? -sc : sc;
            if (ctrl_reg[2+k] && iter >= m[41:32] && iter < m[51:42]) begin
                for (int j = 0; j < 3; j++) begin
                    t[j] = clamp32((t[j] * sc) >>> spc_pkg::FRAC_BITS);
                end
                w = clamp32((w * sc) >>> spc_pkg::FRAC_BITS);
                d = (d * asc) >>> spc_pkg::FRAC_BITS;
                if (d > 64'sd2147483647) begin
                    d = 64'sd2147483647;
                end
            end
        end
        r.x = 32'(t[0]);
        r.y = 32'(t[1]);
        r.z = 32'(t[2]);
        r.w = 32'(w);
        r.distance = 31'(d);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        point_t e;
        if (!aresetn) begin
            errors = 0;
            pending <= 0;
            requests_taken <= 0;
            ctrl_reg <= spc_pkg::CONTROL_RESET;
            offset_reg <= spc_pkg::OFFSET_RESET;
            for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
                mult_reg[k] <= spc_pkg::MULT_RESET;
            end
        end else begin
            if (s_valid && s_ready) begin
                expected_points.push_back(transform_point(s_in_x, s_in_y, s_in_z, s_in_w,
                                                          s_in_distance, s_iteration));
                requests_taken <= requests_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected result, count", 1, 0);
                end else begin
                    e = expected_points.pop_front();
                    if (m_out_x !== e.x) report_mismatch("x", m_out_x, e.x);
                    if (m_out_y !== e.y) report_mismatch("y", m_out_y, e.y);
                    if (m_out_z !== e.z) report_mismatch("z", m_out_z, e.z);
                    if (m_out_w !== e.w) report_mismatch("w", m_out_w, e.w);
                    if (m_out_distance !== e.distance) begin
                        report_mismatch("distance", m_out_distance, e.distance);
                    end
                end
            end
            pending <= expected_points.size();
            if (cfg_we) begin
                if (cfg_index == spc_pkg::REG_CONTROL) begin
                    ctrl_reg <= cfg_data[6:0];
                end else if (cfg_index == spc_pkg::REG_OFFSET) begin
                    offset_reg <= cfg_data;
                end else if (cfg_index >= spc_pkg::REG_MULT_FIRST &&
                             cfg_index <= spc_pkg::REG_MULT_LAST) begin
                    mult_reg[3'(cfg_index - spc_pkg::REG_MULT_FIRST)] <= cfg_data[51:0];
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
// top of the scaler regression: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 138;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = spc_pkg::REG_CONTROL;
    logic [59:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_in_x = '0;
    logic signed [31:0] s_in_y = '0;
    logic signed [31:0] s_in_z = '0;
    logic signed [31:0] s_in_w = '0;
    logic [30:0]        s_in_distance = '0;
    logic [9:0]         s_iteration = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic signed [31:0] m_out_z;
    logic signed [31:0] m_out_w;
    logic [30:0]        m_out_distance;
    int                 errors;
    int                 pending;
    int                 requests_taken;
    int                 cycles = 0;
    int                 ready_hold = 0;
    bit                 no_gaps = 0;

    always #5 aclk = ~aclk;

    spherical_to_cartesian_scaler dut (.*);

    spc_checker scoreboard (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("spherical_to_cartesian_scaler regression: fail");
            $finish;
        end
    end

    // receiver stalls: mostly short, a few long, some long open stretches
    always @(negedge aclk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (r < 88) begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else if (r < 94) begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(10, 50);
            end else begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(100, 300);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_pipeline();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (45) @(negedge aclk);
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w,
                              input logic [30:0] d, input logic [9:0] it);
        int taken;
        int r;
        int gap;
        s_in_x = x;
        s_in_y = y;
        s_in_z = z;
        s_in_w = w;
        s_in_distance = d;
        s_iteration = it;
        s_valid = 1'b1;
        taken = requests_taken;
        do @(negedge aclk); while (requests_taken == taken);
        r = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) :
              (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] edges [6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                  32'h1, 32'h01000000};
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return edges[$urandom_range(0, 5)];
            3: return $urandom_range(0, 32'h1FFFFFFF) - 32'h10000000;
            default: return $urandom_range(0, 32'h0FFFFFFF) - 32'h08000000;
        endcase
    endfunction

    function automatic logic [51:0] pick_multiplier();
        logic [31:0] sc;
        logic [9:0]  first;
        logic [9:0]  stop;
        case ($urandom_range(0, 7))
            0: sc = 32'h80000000;
            1: sc = 32'h7FFFFFFF;
            2: sc = 32'h0;
            3: sc = $urandom;
            default: sc = $urandom_range(32'h00400000, 32'h02000000) ^
                          ({32{$urandom_range(0, 1) == 1}} & 32'hFFFFFFFF);
        endcase
        first = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 8));
        stop = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(4, 20));
        return {stop, first, sc};
    endfunction

    task automatic configure(input int phase);
        logic [59:0] off;
        logic [2:0]  idx;
        case (phase)
            1: begin
                write_reg(spc_pkg::REG_CONTROL, '0);
                write_reg(spc_pkg::REG_OFFSET, '0);
                for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
                    idx = spc_pkg::REG_MULT_FIRST + 3'(k);
                    write_reg(idx, '0);
                end
            end
            2: begin
                write_reg(spc_pkg::REG_CONTROL, 60'h7F);
                write_reg(spc_pkg::REG_OFFSET, '1);
                for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
                    idx = spc_pkg::REG_MULT_FIRST + 3'(k);
                    write_reg(idx, 60'hFFFFFFFFFFFFF);
                end
            end
            3: begin
                write_reg(spc_pkg::REG_CONTROL, 60'h7C | spc_pkg::MODE_RADIUS_Y);
                write_reg(spc_pkg::REG_OFFSET, {20'h7FFFF, 20'h80000, 20'h7FFFF});
                for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
                    idx = spc_pkg::REG_MULT_FIRST + 3'(k);
                    write_reg(idx, {10'h3FF, 10'h0, 32'h7FFFFFFF});
                end
            end
            default: begin
                off = 60'({$urandom, $urandom});
                write_reg(spc_pkg::REG_CONTROL, 60'($urandom_range(0, 127)));
                write_reg(spc_pkg::REG_OFFSET,
                          $urandom_range(0, 1) ? off : off & 60'h0FFFF0FFFF0FFFF);
                for (int k = 0; k < spc_pkg::NUM_MULT; k++) begin
                    idx = spc_pkg::REG_MULT_FIRST + 3'(k);
                    write_reg(idx, pick_multiplier());
                end
            end
        endcase
    endtask

    initial begin
        logic [9:0]  it;
        logic [30:0] d;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // default setup: radius in x, no multipliers
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 10'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   31'h7FFFFFFF, 10'h3FF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h0, 10'h0);
        send_point(32'h01000000, 32'h03243F6A, 32'hFCDBC096, 32'h1, 31'h01000000, 10'h1);
        send_point(32'h01000000, 32'h01921FB5, 32'hFE6DE04B, 32'hFFFFFFFF, 31'h1, 10'h2);
        send_point(32'h7FFFFFFF, 32'h01921FB5, 32'h0, 32'h0, 31'h7FFFFFFF, 10'h3);
        send_point(32'h80000000, 32'h0, 32'h01921FB5, 32'h0, 31'h5, 10'h200);
        drain_pipeline();
        for (int md = spc_pkg::MODE_PASS; md <= spc_pkg::MODE_RADIUS_Y; md++) begin
            write_reg(spc_pkg::REG_CONTROL, 60'(7'h7C | md));
            send_point(32'h02000000, 32'h00C90FDA, 32'hFF36F026, 32'h7FFFFFFF,
                       31'h7FFFFFFF, 10'h1);
            send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 31'h1, 10'h5);
            send_point(32'hFE000000, 32'h80000000, 32'h7FFFFFFF, 32'h12345678, 31'h0, 10'h3FF);
            drain_pipeline();
        end

        for (int ph = 1; ph <= PHASES; ph++) begin
            configure(ph);
            no_gaps = (ph % 4) == 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = $urandom_range(0, 2) == 0 ? 10'($urandom) : 10'($urandom_range(0, 24));
                d = $urandom_range(0, 3) == 0 ? 31'($urandom) :
                    31'($urandom_range(0, 32'h04000000));
                send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), d, it);
                if (ph == 6 && n == PHASE_ITEMS / 2) begin
                    s_valid = 1'b0;
                    while (pending != 0) @(negedge aclk);
                end
            end
            s_valid = 1'b0;
            drain_pipeline();
        end

        if (errors == 0 && pending == 0) begin
            $display("spherical_to_cartesian_scaler regression: pass");
        end else begin
            $display("spherical_to_cartesian_scaler regression: fail");
        end
        $finish;
    end

endmodule
